// ----- hw/rtl/ptc_pkg.sv -----
`timescale 1ns / 1ps
package ptc_pkg;

  localparam int unsigned DivSteps = 32;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } trim_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] tf;
    logic        fault;
    logic        dbl;
  } side_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] rem;
    logic [31:0] nq;
    logic [31:0] div;
    side_t       side;
  } div_st_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic logic [31:0] zx16(input logic [15:0] w);
    return {16'd0, w};
  endfunction

endpackage

// ----- hw/rtl/pressure_temperature_compensation_unit.sv -----
`timescale 1ns / 1ps
// Each input beat passes the front stages, the 32-stage restoring divider and the back stages.
// Throughput: one beat per cycle unless stalled; the divider takes one quotient bit per stage.
// The whole pipeline advances together and holds while the output beat waits.
// Reset clears all valid bits and the trim registers to zero.
module pressure_temperature_compensation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] temperature_centi,
  output logic [31:0] fine_temperature,
  output logic [31:0] pressure_pa,
  output logic        divide_fault,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [1:0] RegTemp  = 2'd0;
  localparam logic [1:0] RegPressA = 2'd1;
  localparam logic [1:0] RegPressB = 2'd2;
  localparam logic [1:0] RegPressC = 2'd3;

  logic [47:0] temp_trim;
  logic [63:0] press_trim_a, press_trim_b;
  logic [15:0] press_trim_c;
  logic        en;
  ptc_pkg::trim_t   trim;
  ptc_pkg::div_st_t front_out, div_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim    <= '0;
      press_trim_a <= '0;
      press_trim_b <= '0;
      press_trim_c <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegTemp:   temp_trim    <= cfg_data[47:0];
        RegPressA: press_trim_a <= cfg_data;
        RegPressB: press_trim_b <= cfg_data;
        RegPressC: press_trim_c <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  assign trim.t1 = temp_trim[15:0];
  assign trim.t2 = temp_trim[31:16];
  assign trim.t3 = temp_trim[47:32];
  assign trim.p1 = press_trim_a[15:0];
  assign trim.p2 = press_trim_a[31:16];
  assign trim.p3 = press_trim_a[47:32];
  assign trim.p4 = press_trim_a[63:48];
  assign trim.p5 = press_trim_b[15:0];
  assign trim.p6 = press_trim_b[31:16];
  assign trim.p7 = press_trim_b[47:32];
  assign trim.p8 = press_trim_b[63:48];
  assign trim.p9 = press_trim_c;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ptc_front u_front (
    .clk(clk), .rst(rst), .en(en), .trim(trim),
    .in_valid(in_valid), .raw_temperature(raw_temperature),
    .raw_pressure(raw_pressure), .dout(front_out)
  );

  ptc_div u_div (
    .clk(clk), .rst(rst), .en(en), .din(front_out), .dout(div_out)
  );

  ptc_back u_back (
    .clk(clk), .rst(rst), .en(en), .trim(trim), .din(div_out),
    .out_valid(out_valid), .temperature_centi(temperature_centi),
    .fine_temperature(fine_temperature), .pressure_pa(pressure_pa),
    .divide_fault(divide_fault)
  );

endmodule

// ----- hw/rtl/ptc_front.sv -----
`timescale 1ns / 1ps
module ptc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ptc_pkg::trim_t   trim,
  input  logic             in_valid,
  input  logic [19:0]      raw_temperature,
  input  logic [19:0]      raw_pressure,
  output ptc_pkg::div_st_t dout
);

  logic [8:0]  v;
  logic [31:0] r1_a, r1_b;
  logic [19:0] r1_ap, r2_ap, r3_ap, r4_ap, r5_ap, r6_ap, r7_ap;
  logic [31:0] r2_m1, r2_bb;
  logic [31:0] r3_v1, r3_m3;
  logic [31:0] r4_tf;
  logic [31:0] r5_tcm, r5_sq, r5_m5, r5_m2, r5_tf;
  logic [31:0] r6_tc, r6_v2a, r6_m3p, r6_m5, r6_m2, r6_tf;
  logic [31:0] r7_v2, r7_v1, r7_tc, r7_tf;
  logic [31:0] r8_v1y, r8_d, r8_tc, r8_tf;
  logic [31:0] r9_div, r9_pm, r9_tc, r9_tf;
  logic [31:0] at32, pv1, q;

  assign at32 = {12'd0, raw_temperature};
  assign pv1  = ptc_pkg::asr(r4_tf, 5'd1) - 32'd64000;
  assign q    = ptc_pkg::asr(pv1, 5'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v          <= '0;
      dout.valid <= 1'b0;
    end else if (en) begin
      v <= {v[7:0], in_valid};

      r1_a  <= (at32 >> 3) - (ptc_pkg::zx16(trim.t1) << 1);
      r1_b  <= (at32 >> 4) - ptc_pkg::zx16(trim.t1);
      r1_ap <= raw_pressure;

      r2_m1 <= r1_a * ptc_pkg::sx16(trim.t2);
      r2_bb <= r1_b * r1_b;
      r2_ap <= r1_ap;

      r3_v1 <= ptc_pkg::asr(r2_m1, 5'd11);
      r3_m3 <= ptc_pkg::asr(r2_bb, 5'd12) * ptc_pkg::sx16(trim.t3);
      r3_ap <= r2_ap;

      r4_tf <= r3_v1 + ptc_pkg::asr(r3_m3, 5'd14);
      r4_ap <= r3_ap;

      r5_tcm <= (r4_tf << 2) + r4_tf + 32'd128;
      r5_sq  <= q * q;
      r5_m5  <= pv1 * ptc_pkg::sx16(trim.p5);
      r5_m2  <= ptc_pkg::sx16(trim.p2) * pv1;
      r5_tf  <= r4_tf;
      r5_ap  <= r4_ap;

      r6_tc  <= ptc_pkg::asr(r5_tcm, 5'd8);
      r6_v2a <= ptc_pkg::asr(r5_sq, 5'd11) * ptc_pkg::sx16(trim.p6);
      r6_m3p <= ptc_pkg::sx16(trim.p3) * ptc_pkg::asr(r5_sq, 5'd13);
      r6_m5  <= r5_m5;
      r6_m2  <= r5_m2;
      r6_tf  <= r5_tf;
      r6_ap  <= r5_ap;

      r7_v2 <= ptc_pkg::asr(r6_v2a + (r6_m5 << 1), 5'd2) + (ptc_pkg::sx16(trim.p4) << 16);
      r7_v1 <= ptc_pkg::asr(ptc_pkg::asr(r6_m3p, 5'd3) + ptc_pkg::asr(r6_m2, 5'd1), 5'd18);
      r7_tc <= r6_tc;
      r7_tf <= r6_tf;
      r7_ap <= r6_ap;

      r8_v1y <= (32'd32768 + r7_v1) * ptc_pkg::zx16(trim.p1);
      r8_d   <= (32'd1048576 - {12'd0, r7_ap}) - ptc_pkg::asr(r7_v2, 5'd12);
      r8_tc  <= r7_tc;
      r8_tf  <= r7_tf;

      r9_div <= ptc_pkg::asr(r8_v1y, 5'd15);
      r9_pm  <= r8_d * 32'd3125;
      r9_tc  <= r8_tc;
      r9_tf  <= r8_tf;

      dout.valid      <= v[8];
      dout.rem        <= '0;
      dout.div        <= r9_div;
      dout.nq         <= r9_pm[31] ? r9_pm : (r9_pm << 1);
      dout.side.tc    <= r9_tc;
      dout.side.tf    <= r9_tf;
      dout.side.fault <= (r9_div == 32'd0);
      dout.side.dbl   <= r9_pm[31];
    end
  end

endmodule

// ----- hw/rtl/ptc_div.sv -----
`timescale 1ns / 1ps
module ptc_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ptc_pkg::div_st_t din,
  output ptc_pkg::div_st_t dout
);

  ptc_pkg::div_st_t st [ptc_pkg::DivSteps];
  ptc_pkg::div_st_t st_next [ptc_pkg::DivSteps];

  always_comb begin
    for (int i = 0; i < ptc_pkg::DivSteps; i++) begin
      ptc_pkg::div_st_t src;
      logic [32:0] t;
      logic        ge;
      src = (i == 0) ? din : st[i-1];
      t   = {src.rem, src.nq[31]};
      ge  = (t >= {1'b0, src.div});
      st_next[i]       = src;
      st_next[i].rem   = ge ? 32'(t - {1'b0, src.div}) : t[31:0];
      st_next[i].nq    = {src.nq[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptc_pkg::DivSteps; i++) begin
        st[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < ptc_pkg::DivSteps; i++) begin
        st[i] <= st_next[i];
      end
    end
  end

  assign dout = st[ptc_pkg::DivSteps-1];

endmodule

// ----- hw/rtl/ptc_back.sv -----
`timescale 1ns / 1ps
module ptc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ptc_pkg::trim_t   trim,
  input  ptc_pkg::div_st_t din,
  output logic             out_valid,
  output logic [31:0]      temperature_centi,
  output logic [31:0]      fine_temperature,
  output logic [31:0]      pressure_pa,
  output logic             divide_fault
);

  logic [2:0]    v;
  logic [31:0]   b1_p, b2_p, b2_sq, b2_m8, b3_p, b3_w1, b3_w2;
  ptc_pkg::side_t b1_s, b2_s, b3_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[1:0], din.valid};
      out_valid <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p  <= din.side.dbl ? (din.nq << 1) : din.nq;
      b1_s  <= din.side;

      b2_sq <= (b1_p >> 3) * (b1_p >> 3);
      b2_m8 <= (b1_p >> 2) * ptc_pkg::sx16(trim.p8);
      b2_p  <= b1_p;
      b2_s  <= b1_s;

      b3_w1 <= ptc_pkg::asr(ptc_pkg::sx16(trim.p9) * (b2_sq >> 13), 5'd12);
      b3_w2 <= ptc_pkg::asr(b2_m8, 5'd13);
      b3_p  <= b2_p;
      b3_s  <= b2_s;

      temperature_centi <= b3_s.tc;
      fine_temperature  <= b3_s.tf;
      divide_fault      <= b3_s.fault;
      pressure_pa       <= b3_s.fault ? 32'd0 :
        b3_p + ptc_pkg::asr(b3_w1 + b3_w2 + ptc_pkg::sx16(trim.p7), 5'd4);
    end
  end

endmodule

// ----- hw/rtl/ptc_checker.sv -----
`timescale 1ns / 1ps
module ptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pressure_pa,
  input logic        divide_fault
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_fault |-> pressure_pa == 32'd0)
    else $error("divide fault with nonzero pressure");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .pressure_pa(pressure_pa), .divide_fault(divide_fault)
);
